// ----- design/pfp_pkg.sv -----
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and result codes for the particle sensor frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam logic [2:0] KIND_MEASUREMENT = 3'd0;
    localparam logic [2:0] KIND_COEFFICIENT = 3'd1;
    localparam logic [2:0] KIND_ACK         = 3'd2;
    localparam logic [2:0] KIND_NACK        = 3'd3;
    localparam logic [2:0] KIND_ERROR       = 3'd4;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_BAD_LENGTH   = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM     = 2'd2;
    localparam logic [1:0] ERR_COMMAND      = 2'd3;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [1:0]  error_code;
        logic        from_autosend;
        logic [15:0] pm1_0;
        logic [15:0] pm2_5;
        logic [15:0] pm4_0;
        logic [15:0] pm10;
        logic        small_sizes_valid;
        logic [7:0]  coefficient;
    } pfp_result_t;

endpackage

// ----- design/particle_sensor_frame_parser.sv -----
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Frame parser for a particulate sensor serial link, with a two-entry
// result buffer toward the consumer.
// ----------------------------------------------------------------------------
// One received byte is taken per clock on the s_ channel while s_ready is
// high; the frame state machine handles it in that cycle, and any result it
// closes is registered in the output register, or in the skid register if
// that one is held, before it shows on the m_ channel. With m_ready high the
// block sustains one byte per cycle; the result side holds two entries, and
// s_ready drops only while both are full. The cfg port writes the autosend
// mode bit, is always ready, and discards any partial frame.
module particle_sensor_frame_parser
    import pfp_pkg::*;
#(
    parameter int MAX_AUTOSEND_LEN = 30
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_restart,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [1:0]  m_error_code,
    output logic        m_from_autosend,
    output logic [15:0] m_pm1_0,
    output logic [15:0] m_pm2_5,
    output logic [15:0] m_pm4_0,
    output logic [15:0] m_pm10,
    output logic        m_small_sizes_valid,
    output logic [7:0]  m_coefficient
);

    logic        byte_accept;
    logic        res_valid;
    pfp_result_t res;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    pfp_result_t out_reg, out_next;
    pfp_result_t skid_reg, skid_next;
    logic        pop;
    logic        push;

    assign cfg_ready   = 1'b1;
    assign s_ready     = !skid_valid_reg;
    assign byte_accept = s_valid && s_ready;

    pfp_parser #(
        .MAX_LEN (MAX_AUTOSEND_LEN)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .restart     (s_restart),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_mode    (cfg_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign pop  = out_valid_reg && m_ready;
    assign push = byte_accept && res_valid;

    // output register with skid behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_result_kind       = out_reg.result_kind;
    assign m_error_code        = out_reg.error_code;
    assign m_from_autosend     = out_reg.from_autosend;
    assign m_pm1_0             = out_reg.pm1_0;
    assign m_pm2_5             = out_reg.pm2_5;
    assign m_pm4_0             = out_reg.pm4_0;
    assign m_pm10              = out_reg.pm10;
    assign m_small_sizes_valid = out_reg.small_sizes_valid;
    assign m_coefficient       = out_reg.coefficient;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_ERROR) |-> (m_error_code != ERR_NONE))
        else $error("error result without an error code");

    a_code_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_ERROR) |-> (m_error_code == ERR_NONE))
        else $error("error code on a non-error result");

    a_small_sizes_polled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_small_sizes_valid) |->
            (m_result_kind == KIND_MEASUREMENT && !m_from_autosend))
        else $error("small sizes flagged outside a polled measurement");

    a_full_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("buffered result lost while the consumer stalled");
`endif

endmodule

// ----- design/pfp_parser.sv -----
// ----------------------------------------------------------------------------
// pfp_parser
// Byte-wise frame state machine: consumes one received byte per accepted
// beat and produces at most one result for it in the same cycle.
// ----------------------------------------------------------------------------
module pfp_parser
    import pfp_pkg::*;
#(
    parameter int MAX_LEN = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_accept,
    input  logic [7:0]  rx_byte,
    input  logic        restart,
    input  logic        cfg_write,
    input  logic        cfg_mode,
    output logic        res_valid,
    output pfp_result_t res
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    localparam logic [7:0]  HDR_AS_FIRST  = 8'h42;
    localparam logic [7:0]  HDR_AS_SECOND = 8'h4D;
    localparam logic [7:0]  HDR_POLLED    = 8'h40;
    localparam logic [7:0]  ACK_BYTE      = 8'hA5;
    localparam logic [7:0]  NACK_BYTE     = 8'h96;
    localparam logic [7:0]  LEN_COEF      = 8'h02;
    localparam logic [7:0]  LEN_SHORT     = 8'h05;
    localparam logic [7:0]  LEN_LONG      = 8'h0D;
    localparam logic [7:0]  CMD_COEF      = 8'h10;
    localparam logic [15:0] AS_MIN_LEN    = 16'd8;
    localparam logic [15:0] AS_MAX_LEN    = 16'(MAX_LEN);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_AS_GOT42,
        PH_AS_LENHI,
        PH_AS_LENLO,
        PH_AS_BODY,
        PH_PL_LEN,
        PH_PL_BODY,
        PH_ACK1
    } phase_t;

    phase_t             phase_reg, phase_next, phase_cur, hunt_phase;
    logic               mode_reg, mode_next;
    logic               ack_pos_reg, ack_pos_next, hunt_ack;
    logic [LEN_W-1:0]   frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]   byte_idx_reg, byte_idx_next;
    logic [15:0]        run_sum_reg, run_sum_next;
    logic [7:0]         chk_hi_reg, chk_hi_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [15:0]        pm1_reg, pm1_next;
    logic [15:0]        pm25_reg, pm25_next;
    logic [15:0]        pm4_reg, pm4_next;
    logic [15:0]        pm10_reg, pm10_next;
    logic [7:0]         coef_reg, coef_next;

    logic [15:0]        as_len;
    logic [LEN_W:0]     idx_plus2;
    logic [LEN_W:0]     len_ext;
    logic [7:0]         pl_expect;
    logic [15:0]        shifted_byte_pm1, shifted_byte_pm25, shifted_byte_pm4, shifted_byte_pm10;

    assign phase_cur = restart ? PH_HUNT : phase_reg;
    assign as_len    = {chk_hi_reg, rx_byte};
    assign idx_plus2 = {1'b0, byte_idx_reg} + (LEN_W + 1)'(2);
    assign len_ext   = {1'b0, frame_len_reg};
    assign pl_expect = 8'h00 - run_sum_reg[7:0];

    assign shifted_byte_pm1  = {pm1_reg[7:0], rx_byte};
    assign shifted_byte_pm25 = {pm25_reg[7:0], rx_byte};
    assign shifted_byte_pm4  = {pm4_reg[7:0], rx_byte};
    assign shifted_byte_pm10 = {pm10_reg[7:0], rx_byte};

    // header search while hunting
    always_comb begin
        hunt_phase = PH_HUNT;
        hunt_ack   = ack_pos_reg;
        if (mode_reg) begin
            if (rx_byte == HDR_AS_FIRST) begin
                hunt_phase = PH_AS_GOT42;
            end
        end else if (rx_byte == HDR_POLLED) begin
            hunt_phase = PH_PL_LEN;
        end else if (rx_byte == ACK_BYTE || rx_byte == NACK_BYTE) begin
            hunt_ack   = (rx_byte == ACK_BYTE);
            hunt_phase = PH_ACK1;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        ack_pos_next   = ack_pos_reg;
        frame_len_next = frame_len_reg;
        byte_idx_next  = byte_idx_reg;
        run_sum_next   = run_sum_reg;
        chk_hi_next    = chk_hi_reg;
        cmd_next       = cmd_reg;
        pm1_next       = pm1_reg;
        pm25_next      = pm25_reg;
        pm4_next       = pm4_reg;
        pm10_next      = pm10_reg;
        coef_next      = coef_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (byte_accept) begin
            phase_next = phase_cur;
            case (phase_cur)
                PH_HUNT: begin
                    phase_next   = hunt_phase;
                    ack_pos_next = hunt_ack;
                end
                PH_AS_GOT42: begin
                    if (rx_byte == HDR_AS_SECOND) begin
                        phase_next = PH_AS_LENHI;
                    end else if (rx_byte == HDR_AS_FIRST) begin
                        phase_next = PH_AS_GOT42;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_AS_LENHI: begin
                    chk_hi_next = rx_byte;
                    phase_next  = PH_AS_LENLO;
                end
                PH_AS_LENLO: begin
                    if (as_len < AS_MIN_LEN || as_len > AS_MAX_LEN) begin
                        res_valid      = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_BAD_LENGTH;
                        phase_next     = PH_HUNT;
                    end else begin
                        frame_len_next = rx_byte[LEN_W-1:0];
                        byte_idx_next  = '0;
                        run_sum_next   = 16'(HDR_AS_FIRST) + 16'(HDR_AS_SECOND)
                                       + 16'(chk_hi_reg) + 16'(rx_byte);
                        phase_next     = PH_AS_BODY;
                    end
                end
                PH_AS_BODY: begin
                    if (idx_plus2 < len_ext) begin
                        run_sum_next = run_sum_reg + 16'(rx_byte);
                        if (byte_idx_reg == LEN_W'(2) || byte_idx_reg == LEN_W'(3)) begin
                            pm25_next = shifted_byte_pm25;
                        end
                        if (byte_idx_reg == LEN_W'(4) || byte_idx_reg == LEN_W'(5)) begin
                            pm10_next = shifted_byte_pm10;
                        end
                        byte_idx_next = byte_idx_reg + LEN_W'(1);
                    end else if (idx_plus2 == len_ext) begin
                        chk_hi_next   = rx_byte;
                        byte_idx_next = byte_idx_reg + LEN_W'(1);
                    end else begin
                        res_valid = 1'b1;
                        if (as_len != run_sum_reg) begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_CHECKSUM;
                        end else begin
                            res.result_kind   = KIND_MEASUREMENT;
                            res.from_autosend = 1'b1;
                            res.pm2_5         = pm25_reg;
                            res.pm10          = pm10_reg;
                        end
                        phase_next = PH_HUNT;
                    end
                end
                PH_PL_LEN: begin
                    if (rx_byte == LEN_COEF || rx_byte == LEN_SHORT || rx_byte == LEN_LONG) begin
                        frame_len_next = rx_byte[LEN_W-1:0];
                        byte_idx_next  = '0;
                        run_sum_next   = 16'(HDR_POLLED) + 16'(rx_byte);
                        phase_next     = PH_PL_BODY;
                    end else begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_BAD_LENGTH;
                        phase_next      = PH_HUNT;
                    end
                end
                PH_PL_BODY: begin
                    if (byte_idx_reg < frame_len_reg) begin
                        run_sum_next = run_sum_reg + 16'(rx_byte);
                        if (byte_idx_reg == '0) begin
                            cmd_next = rx_byte;
                        end
                        if (frame_len_reg == LEN_COEF[LEN_W-1:0]) begin
                            if (byte_idx_reg == LEN_W'(1)) begin
                                coef_next = rx_byte;
                            end
                        end else if (frame_len_reg == LEN_SHORT[LEN_W-1:0]) begin
                            if (byte_idx_reg == LEN_W'(1) || byte_idx_reg == LEN_W'(2)) begin
                                pm25_next = shifted_byte_pm25;
                            end
                            if (byte_idx_reg == LEN_W'(3) || byte_idx_reg == LEN_W'(4)) begin
                                pm10_next = shifted_byte_pm10;
                            end
                        end else begin
                            if (byte_idx_reg == LEN_W'(1) || byte_idx_reg == LEN_W'(2)) begin
                                pm1_next = shifted_byte_pm1;
                            end
                            if (byte_idx_reg == LEN_W'(3) || byte_idx_reg == LEN_W'(4)) begin
                                pm25_next = shifted_byte_pm25;
                            end
                            if (byte_idx_reg == LEN_W'(5) || byte_idx_reg == LEN_W'(6)) begin
                                pm4_next = shifted_byte_pm4;
                            end
                            if (byte_idx_reg == LEN_W'(7) || byte_idx_reg == LEN_W'(8)) begin
                                pm10_next = shifted_byte_pm10;
                            end
                        end
                        byte_idx_next = byte_idx_reg + LEN_W'(1);
                    end else begin
                        res_valid = 1'b1;
                        if (frame_len_reg == LEN_COEF[LEN_W-1:0]) begin
                            if (cmd_reg != CMD_COEF) begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_COMMAND;
                            end else if (rx_byte != pl_expect) begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_CHECKSUM;
                            end else begin
                                res.result_kind = KIND_COEFFICIENT;
                                res.coefficient = coef_reg;
                            end
                        end else if (rx_byte != pl_expect) begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_CHECKSUM;
                        end else begin
                            res.result_kind = KIND_MEASUREMENT;
                            res.pm2_5       = pm25_reg;
                            res.pm10        = pm10_reg;
                            if (frame_len_reg == LEN_LONG[LEN_W-1:0]) begin
                                res.pm1_0             = pm1_reg;
                                res.pm4_0             = pm4_reg;
                                res.small_sizes_valid = 1'b1;
                            end
                        end
                        phase_next = PH_HUNT;
                    end
                end
                PH_ACK1: begin
                    if (rx_byte == (ack_pos_reg ? ACK_BYTE : NACK_BYTE)) begin
                        res_valid       = 1'b1;
                        res.result_kind = ack_pos_reg ? KIND_ACK : KIND_NACK;
                        phase_next      = PH_HUNT;
                    end else begin
                        phase_next   = hunt_phase;
                        ack_pos_next = hunt_ack;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // a mode write drops any partial frame
        if (cfg_write) begin
            mode_next  = cfg_mode;
            phase_next = PH_HUNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            mode_reg      <= 1'b0;
            ack_pos_reg   <= 1'b0;
            frame_len_reg <= '0;
            byte_idx_reg  <= '0;
        end else begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            ack_pos_reg   <= ack_pos_next;
            frame_len_reg <= frame_len_next;
            byte_idx_reg  <= byte_idx_next;
        end
        run_sum_reg <= run_sum_next;
        chk_hi_reg  <= chk_hi_next;
        cmd_reg     <= cmd_next;
        pm1_reg     <= pm1_next;
        pm25_reg    <= pm25_next;
        pm4_reg     <= pm4_next;
        pm10_reg    <= pm10_next;
        coef_reg    <= coef_next;
    end

endmodule

// ----- verif/tb_particle_sensor_frame_parser.sv -----
// ----------------------------------------------------------------------------
// tb_particle_sensor_frame_parser
// Self-checking bench for the sensor frame parser. A short table of bytes
// hits acks, nacks, bad lengths, the command check and the mode register.
// Random autosend and polled frames follow, mixed with noise, cut frames
// and restarts. Every byte goes through a behavioral parser in the bench,
// and each result beat is checked field by field against its prediction,
// under three idle patterns and one long consumer stall.
// ----------------------------------------------------------------------------
module tb_particle_sensor_frame_parser;
    import pfp_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int MIN_AS_LEN = 8;
    localparam int MAX_AS_LEN = 30;

    localparam logic [7:0] HDR_AS0   = 8'h42;
    localparam logic [7:0] HDR_AS1   = 8'h4D;
    localparam logic [7:0] HDR_PL    = 8'h40;
    localparam logic [7:0] BYTE_ACK  = 8'hA5;
    localparam logic [7:0] BYTE_NACK = 8'h96;
    localparam logic [7:0] CMD_COEF  = 8'h10;
    localparam logic [7:0] LEN_COEF  = 8'h02;
    localparam logic [7:0] LEN_SHORT = 8'h05;
    localparam logic [7:0] LEN_LONG  = 8'h0D;

    typedef enum logic [3:0] {
        PH_HUNT, PH_AS_GOT42, PH_AS_LENHI, PH_AS_LENLO, PH_AS_BODY,
        PH_PL_LEN, PH_PL_BODY, PH_ACK1
    } parse_phase_t;

    typedef struct packed {
        logic        is_cfg;
        logic [7:0]  data;
        logic        rs;
        logic        typed;
        pfp_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_restart = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_result_kind;
    logic [1:0]  m_error_code;
    logic        m_from_autosend;
    logic [15:0] m_pm1_0;
    logic [15:0] m_pm2_5;
    logic [15:0] m_pm4_0;
    logic [15:0] m_pm10;
    logic        m_small_sizes_valid;
    logic [7:0]  m_coefficient;

    // parser state
    parse_phase_t p_phase   = PH_HUNT;
    logic         p_mode    = 1'b0;
    logic         p_ack_pos = 1'b0;
    logic [7:0]   p_len     = '0;
    logic [4:0]   p_idx     = '0;
    logic [15:0]  p_sum     = '0;
    logic [7:0]   p_chk_hi  = '0;
    logic [7:0]   p_cmd     = '0;
    logic [15:0]  p_pm1     = '0;
    logic [15:0]  p_pm25    = '0;
    logic [15:0]  p_pm4     = '0;
    logic [15:0]  p_pm10    = '0;
    logic [7:0]   p_coef    = '0;

    pfp_result_t results_due[$];
    logic [7:0]  marks[5] = '{HDR_AS0, HDR_AS1, HDR_PL, BYTE_ACK, BYTE_NACK};

    int   s_idle_pct  = 0;
    int   m_idle_pct  = 0;
    logic hold_req    = 1'b0;
    logic cut_pending = 1'b0;
    int   n_bytes     = 0;
    int   n_results   = 0;
    int   n_meas      = 0;
    int   n_coef      = 0;
    int   n_acks      = 0;
    int   n_errs      = 0;
    int   n_fail      = 0;

    particle_sensor_frame_parser #(
        .MAX_AUTOSEND_LEN(MAX_AS_LEN)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .s_restart          (s_restart),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_error_code       (m_error_code),
        .m_from_autosend    (m_from_autosend),
        .m_pm1_0            (m_pm1_0),
        .m_pm2_5            (m_pm2_5),
        .m_pm4_0            (m_pm4_0),
        .m_pm10             (m_pm10),
        .m_small_sizes_valid(m_small_sizes_valid),
        .m_coefficient      (m_coefficient)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * 200000);
        $display("tb_particle_sensor_frame_parser NOT OK");
        $finish;
    end

    function automatic pfp_result_t kind_only(logic [2:0] kind, logic [1:0] code);
        pfp_result_t r;
        r = '0;
        r.result_kind = kind;
        r.error_code = code;
        return r;
    endfunction

    function automatic void hunt_on(logic [7:0] b);
        if (p_mode) begin
            if (b == HDR_AS0) p_phase = PH_AS_GOT42;
        end else if (b == HDR_PL) begin
            p_phase = PH_PL_LEN;
        end else if (b == BYTE_ACK || b == BYTE_NACK) begin
            p_ack_pos = (b == BYTE_ACK);
            p_phase = PH_ACK1;
        end
    endfunction

    function automatic bit parse_rx_byte(logic [7:0] b, logic rs, output pfp_result_t res);
        logic [15:0] len16;
        logic [7:0]  chk;
        bit          emit;
        res = '0;
        emit = 0;
        if (rs) p_phase = PH_HUNT;
        case (p_phase)
            PH_HUNT: hunt_on(b);
            PH_AS_GOT42: begin
                if (b == HDR_AS1) p_phase = PH_AS_LENHI;
                else p_phase = (b == HDR_AS0) ? PH_AS_GOT42 : PH_HUNT;
            end
            PH_AS_LENHI: begin
                p_chk_hi = b;
                p_phase = PH_AS_LENLO;
            end
            PH_AS_LENLO: begin
                len16 = {p_chk_hi, b};
                if (len16 < MIN_AS_LEN || len16 > MAX_AS_LEN) begin
                    res = kind_only(KIND_ERROR, ERR_BAD_LENGTH);
                    emit = 1;
                    p_phase = PH_HUNT;
                end else begin
                    p_len = b;
                    p_idx = '0;
                    p_sum = HDR_AS0 + HDR_AS1 + p_chk_hi + b;
                    p_phase = PH_AS_BODY;
                end
            end
            PH_AS_BODY: begin
                if (p_idx + 2 < p_len) begin
                    p_sum = p_sum + b;
                    if (p_idx == 2 || p_idx == 3) p_pm25 = {p_pm25[7:0], b};
                    if (p_idx == 4 || p_idx == 5) p_pm10 = {p_pm10[7:0], b};
                    p_idx = p_idx + 1;
                end else if (p_idx + 2 == p_len) begin
                    p_chk_hi = b;
                    p_idx = p_idx + 1;
                end else begin
                    if ({p_chk_hi, b} != p_sum) begin
                        res = kind_only(KIND_ERROR, ERR_CHECKSUM);
                    end else begin
                        res = kind_only(KIND_MEASUREMENT, ERR_NONE);
                        res.from_autosend = 1'b1;
                        res.pm2_5 = p_pm25;
                        res.pm10 = p_pm10;
                    end
                    emit = 1;
                    p_phase = PH_HUNT;
                end
            end
            PH_PL_LEN: begin
                if (b == LEN_COEF || b == LEN_SHORT || b == LEN_LONG) begin
                    p_len = b;
                    p_idx = '0;
                    p_sum = HDR_PL + b;
                    p_phase = PH_PL_BODY;
                end else begin
                    res = kind_only(KIND_ERROR, ERR_BAD_LENGTH);
                    emit = 1;
                    p_phase = PH_HUNT;
                end
            end
            PH_PL_BODY: begin
                if (p_idx < p_len) begin
                    p_sum = p_sum + b;
                    if (p_idx == 0) p_cmd = b;
                    if (p_len == LEN_COEF) begin
                        if (p_idx == 1) p_coef = b;
                    end else if (p_len == LEN_SHORT) begin
                        if (p_idx == 1 || p_idx == 2) p_pm25 = {p_pm25[7:0], b};
                        if (p_idx == 3 || p_idx == 4) p_pm10 = {p_pm10[7:0], b};
                    end else begin
                        if (p_idx == 1 || p_idx == 2) p_pm1 = {p_pm1[7:0], b};
                        if (p_idx == 3 || p_idx == 4) p_pm25 = {p_pm25[7:0], b};
                        if (p_idx == 5 || p_idx == 6) p_pm4 = {p_pm4[7:0], b};
                        if (p_idx == 7 || p_idx == 8) p_pm10 = {p_pm10[7:0], b};
                    end
                    p_idx = p_idx + 1;
                end else begin
                    chk = 8'h00 - p_sum[7:0];
                    if (p_len == LEN_COEF && p_cmd != CMD_COEF) begin
                        res = kind_only(KIND_ERROR, ERR_COMMAND);
                    end else if (b != chk) begin
                        res = kind_only(KIND_ERROR, ERR_CHECKSUM);
                    end else if (p_len == LEN_COEF) begin
                        res = kind_only(KIND_COEFFICIENT, ERR_NONE);
                        res.coefficient = p_coef;
                    end else begin
                        res = kind_only(KIND_MEASUREMENT, ERR_NONE);
                        res.pm2_5 = p_pm25;
                        res.pm10 = p_pm10;
                        if (p_len == LEN_LONG) begin
                            res.pm1_0 = p_pm1;
                            res.pm4_0 = p_pm4;
                            res.small_sizes_valid = 1'b1;
                        end
                    end
                    emit = 1;
                    p_phase = PH_HUNT;
                end
            end
            PH_ACK1: begin
                if (b == (p_ack_pos ? BYTE_ACK : BYTE_NACK)) begin
                    res = kind_only(p_ack_pos ? KIND_ACK : KIND_NACK, ERR_NONE);
                    emit = 1;
                    p_phase = PH_HUNT;
                end else begin
                    p_phase = PH_HUNT;
                    hunt_on(b);
                end
            end
            default: p_phase = PH_HUNT;
        endcase
        return emit;
    endfunction

    function automatic stim_row_t plain_row(logic [7:0] d);
        stim_row_t r;
        r = '0;
        r.data = d;
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] d, logic [2:0] kind, logic [1:0] code);
        stim_row_t r;
        r = plain_row(d);
        r.typed = 1'b1;
        r.want = kind_only(kind, code);
        return r;
    endfunction

    function automatic stim_row_t mode_row(logic m);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.data = {7'd0, m};
        return r;
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            n_fail++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
        end
    endtask

    task automatic send_beat(logic [7:0] b, logic rs, logic typed, pfp_result_t want);
        pfp_result_t res;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        s_restart <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_bytes++;
        if (parse_rx_byte(b, rs, res) && !typed) results_due.push_back(res);
        if (typed) results_due.push_back(want);
    endtask

    task automatic write_mode(logic m);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        p_mode = m;
        p_phase = PH_HUNT;
    endtask

    task automatic send_random_frame(logic as_mode);
        logic [7:0]  fb[$];
        logic [7:0]  b;
        logic [15:0] sum;
        int          pick;
        int          len;
        int          n_send;
        logic        first_rs;
        pick = $urandom_range(99);
        if (as_mode) begin
            if (pick < 65) begin
                if ($urandom_range(3) == 0) len = $urandom_range(1) ? MIN_AS_LEN : MAX_AS_LEN;
                else len = $urandom_range(MAX_AS_LEN, MIN_AS_LEN);
                if ($urandom_range(9) == 0) fb.push_back(HDR_AS0);
                fb.push_back(HDR_AS0);
                fb.push_back(HDR_AS1);
                fb.push_back(8'h00);
                fb.push_back(8'(len));
                sum = HDR_AS0 + HDR_AS1 + 16'(len);
                repeat (len - 2) begin
                    b = 8'($urandom);
                    sum = sum + b;
                    fb.push_back(b);
                end
                if ($urandom_range(99) < 12) sum = sum ^ 16'($urandom_range(65535, 1));
                fb.push_back(sum[15:8]);
                fb.push_back(sum[7:0]);
            end else if (pick < 80) begin
                fb.push_back(HDR_AS0);
                fb.push_back(HDR_AS1);
                if ($urandom_range(1)) begin
                    fb.push_back(8'($urandom_range(255, 1)));
                    fb.push_back(8'($urandom));
                end else begin
                    fb.push_back(8'h00);
                    if ($urandom_range(1)) fb.push_back(8'($urandom_range(MIN_AS_LEN - 1, 0)));
                    else fb.push_back(8'($urandom_range(255, MAX_AS_LEN + 1)));
                end
            end
        end else begin
            if (pick < 60) begin
                case ($urandom_range(2))
                    0: len = LEN_COEF;
                    1: len = LEN_SHORT;
                    default: len = LEN_LONG;
                endcase
                if ($urandom_range(9) == 0) fb.push_back($urandom_range(1) ? BYTE_ACK : BYTE_NACK);
                fb.push_back(HDR_PL);
                fb.push_back(8'(len));
                sum = HDR_PL + 16'(len);
                for (int i = 0; i < len; i++) begin
                    if (i == 0 && len == LEN_COEF && $urandom_range(4) != 0) b = CMD_COEF;
                    else b = 8'($urandom);
                    sum = sum + b;
                    fb.push_back(b);
                end
                b = 8'h00 - sum[7:0];
                if ($urandom_range(99) < 12) b = b ^ 8'($urandom_range(255, 1));
                fb.push_back(b);
            end else if (pick < 75) begin
                repeat ($urandom_range(3, 2)) fb.push_back($urandom_range(1) ? BYTE_ACK : BYTE_NACK);
            end else if (pick < 85) begin
                fb.push_back(HDR_PL);
                do b = 8'($urandom); while (b == LEN_COEF || b == LEN_SHORT || b == LEN_LONG);
                fb.push_back(b);
            end
        end
        // noise, partly made of header and ack bytes
        if (fb.size() == 0)
            repeat ($urandom_range(6, 1)) fb.push_back($urandom_range(1) ? marks[$urandom_range(4)]
                                                                         : 8'($urandom));
        n_send = fb.size();
        if (n_send > 1 && $urandom_range(14) == 0) n_send = $urandom_range(n_send - 1, 1);
        first_rs = cut_pending ? ($urandom_range(3) != 0) : ($urandom_range(19) == 0);
        cut_pending = (n_send < fb.size());
        for (int i = 0; i < n_send; i++)
            send_beat(fb[i], (i == 0) ? first_rs : ($urandom_range(299) == 0), 1'b0, '0);
    endtask

    initial begin : result_sink
        int          hold_left;
        bit          hold_done;
        pfp_result_t want;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                n_results++;
                if (results_due.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result beat, expected none, actual kind %0d",
                             $time, m_result_kind);
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", want.result_kind, m_result_kind);
                    check_field("error_code", want.error_code, m_error_code);
                    check_field("from_autosend", want.from_autosend, m_from_autosend);
                    check_field("pm1_0", want.pm1_0, m_pm1_0);
                    check_field("pm2_5", want.pm2_5, m_pm2_5);
                    check_field("pm4_0", want.pm4_0, m_pm4_0);
                    check_field("pm10", want.pm10, m_pm10);
                    check_field("small_sizes_valid", want.small_sizes_valid, m_small_sizes_valid);
                    check_field("coefficient", want.coefficient, m_coefficient);
                    case (want.result_kind)
                        KIND_MEASUREMENT: n_meas++;
                        KIND_COEFFICIENT: n_coef++;
                        KIND_ERROR:       n_errs++;
                        default:          n_acks++;
                    endcase
                end
            end
            // one long stall so the output buffer fills and s_ready drops
            if (hold_req && !hold_done) begin
                hold_left = 300;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        int        phase_end;
        // acks, nacks, bad length, command check, header after a lone ack byte
        rows.push_back(plain_row(BYTE_ACK));
        rows.push_back(typed_row(BYTE_ACK, KIND_ACK, ERR_NONE));
        rows.push_back(plain_row(BYTE_NACK));
        rows.push_back(typed_row(BYTE_NACK, KIND_NACK, ERR_NONE));
        rows.push_back(plain_row(HDR_PL));
        rows.push_back(typed_row(8'h07, KIND_ERROR, ERR_BAD_LENGTH));
        rows.push_back(plain_row(HDR_PL));
        rows.push_back(plain_row(LEN_COEF));
        rows.push_back(plain_row(8'h11));
        rows.push_back(plain_row(8'h00));
        rows.push_back(typed_row(8'h00, KIND_ERROR, ERR_COMMAND));
        rows.push_back(plain_row(BYTE_ACK));
        rows.push_back(plain_row(HDR_PL));
        rows.push_back(plain_row(LEN_COEF));
        rows.push_back(plain_row(CMD_COEF));
        rows.push_back(plain_row(8'hFF));
        rows.push_back(plain_row(8'hAF));
        rows.push_back(plain_row(BYTE_NACK));
        rows.push_back(plain_row(BYTE_ACK));
        rows.push_back(typed_row(BYTE_ACK, KIND_ACK, ERR_NONE));
        rows.push_back(mode_row(1'b1));
        rows.push_back(plain_row(HDR_AS0));
        rows.push_back(plain_row(HDR_AS1));
        rows.push_back(plain_row(8'hFF));
        rows.push_back(typed_row(8'hFF, KIND_ERROR, ERR_BAD_LENGTH));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_mode(rows[i].data[0]);
            else send_beat(rows[i].data, rows[i].rs, rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < 6; p++) begin
            write_mode(p % 2);
            case (p / 2)
                0: begin s_idle_pct = 6;  m_idle_pct <= 47; end
                1: begin s_idle_pct = 47; m_idle_pct <= 6;  end
                default: begin s_idle_pct = 0; m_idle_pct <= 0; end
            endcase
            if (p == 4) hold_req <= 1'b1;
            phase_end = n_bytes + 305;
            while (n_bytes < phase_end) send_random_frame(p % 2);
        end

        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d bytes over both modes, three idle patterns and a long stall",
                 n_bytes);
        $display("%0d results: %0d measurements, %0d coefficients, %0d ack/nack, %0d errors",
                 n_results, n_meas, n_coef, n_acks, n_errs);
        if (n_fail == 0) begin
            $display("tb_particle_sensor_frame_parser OK");
        end else begin
            $display("tb_particle_sensor_frame_parser NOT OK");
        end
        $finish;
    end

endmodule
